[rtl/core/gsd_pkg.sv]
// Package: shared widths, codes and control structs for the grid distance map.
package gsd_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  localparam int DIST_W = 13;
  localparam int CFG_W  = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIST_W-1:0] DIST_NONE = 13'h1FFF;
  localparam logic [DIST_W-1:0] DIST_SAT  = 13'd4095;

  localparam logic [1:0] OP_WALL    = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW    = 2'd3;

  localparam logic [1:0] RD_CELL = 2'd0;
  localparam logic [1:0] RD_U    = 2'd1;
  localparam logic [1:0] RD_NB   = 2'd2;

  typedef struct packed {
    logic       in_latch;
    logic       wall_wr;
    logic [1:0] rd_sel;
    logic       clr_start;
    logic       clr_step;
    logic       goal_init;
    logic       pop;
    logic       u_latch;
    logic       du_latch;
    logic       nb_next;
    logic       nb_visit;
    logic       out_load;
  } gsd_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       clr_last;
    logic       q_empty;
    logic       u_wall;
    logic       nb_legal;
    logic       nb_last;
  } gsd_stat_t;

endpackage

[rtl/core/gsd_if.sv]
// Interfaces: request, result and configuration channels.
interface gsd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [5:0] cell_col;
  logic [5:0] cell_row;
  logic       wall_flag;
  modport source (output valid, op, cell_col, cell_row, wall_flag, input ready);
  modport sink   (input valid, op, cell_col, cell_row, wall_flag, output ready);
endinterface

interface gsd_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] cell_distance;
  logic signed [12:0] peak_distance;
  modport source (output valid, cell_distance, peak_distance, input ready);
  modport sink   (input valid, cell_distance, peak_distance, output ready);
endinterface

interface gsd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/gsd_ctrl.sv]
// Controller: sequences writes, reads, the clearing sweep and the search.
module gsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gsd_pkg::gsd_stat_t stat,
  output gsd_pkg::gsd_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RDW   = 4'd2;
  localparam logic [3:0] S_CLR   = 4'd3;
  localparam logic [3:0] S_GOAL  = 4'd4;
  localparam logic [3:0] S_POP   = 4'd5;
  localparam logic [3:0] S_UREAD = 4'd6;
  localparam logic [3:0] S_ULAT  = 4'd7;
  localparam logic [3:0] S_NBRD  = 4'd8;
  localparam logic [3:0] S_NBCHK = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = gsd_pkg::RD_CELL;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.in_latch = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.op)
          gsd_pkg::OP_WALL: begin
            cmd.wall_wr  = 1'b1;
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
          gsd_pkg::OP_COMPUTE: begin
            cmd.clr_start = 1'b1;
            state_nxt     = S_CLR;
          end
          gsd_pkg::OP_READ: begin
            state_nxt = S_RDW;
          end
          default: begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        endcase
      end
      S_RDW: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_GOAL;
      end
      S_GOAL: begin
        cmd.goal_init = 1'b1;
        state_nxt     = S_POP;
      end
      S_POP: begin
        if (stat.q_empty) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_UREAD;
        end
      end
      S_UREAD: begin
        cmd.u_latch = 1'b1;
        cmd.rd_sel  = gsd_pkg::RD_U;
        state_nxt   = S_ULAT;
      end
      S_ULAT: begin
        cmd.du_latch = 1'b1;
        state_nxt    = stat.u_wall ? S_POP : S_NBRD;
      end
      S_NBRD: begin
        cmd.rd_sel = gsd_pkg::RD_NB;
        if (stat.nb_legal) begin
          state_nxt = S_NBCHK;
        end else if (stat.nb_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.nb_next = 1'b1;
        end
      end
      S_NBCHK: begin
        cmd.nb_visit = 1'b1;
        if (stat.nb_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.nb_next = 1'b1;
          state_nxt   = S_NBRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/gsd_dp.sv]
// Datapath: wall, distance and queue memories, search registers, config and result.
module gsd_dp #(
  parameter int MaxCols = gsd_pkg::DEF_MAX_COLS,
  parameter int MaxRows = gsd_pkg::DEF_MAX_ROWS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_op,
  input  logic [5:0]                   in_col,
  input  logic [5:0]                   in_row,
  input  logic                         in_wall,
  input  logic                         cfg_we,
  input  logic [gsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsd_pkg::CFG_W-1:0]     cfg_data,
  input  gsd_pkg::gsd_cmd_t            cmd,
  output gsd_pkg::gsd_stat_t           stat,
  output logic [gsd_pkg::DIST_W-1:0]   out_dist_r,
  output logic [gsd_pkg::DIST_W-1:0]   out_max_r
);

  localparam int CW    = $clog2(MaxCols);
  localparam int RW    = $clog2(MaxRows);
  localparam int AW    = CW + RW;
  localparam int Depth = 1 << AW;
  localparam int DW    = gsd_pkg::DIST_W;

  // configuration
  logic [6:0] gw_r, gh_r, gc_r, gr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= 7'd64;
      gh_r <= 7'd64;
      gc_r <= 7'h7F;
      gr_r <= 7'h7F;
    end else if (cfg_we) begin
      case (cfg_index)
        gsd_pkg::REG_GRID_WIDTH:  gw_r <= cfg_data;
        gsd_pkg::REG_GRID_HEIGHT: gh_r <= cfg_data;
        gsd_pkg::REG_GOAL_COL:    gc_r <= cfg_data;
        gsd_pkg::REG_GOAL_ROW:    gr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [8:0] w_dim, h_dim;
  always_comb begin
    if (gw_r == 7'd0)           w_dim = 9'd1;
    else if (int'(gw_r) > MaxCols) w_dim = 9'(MaxCols);
    else                        w_dim = 9'(gw_r);
    if (gh_r == 7'd0)           h_dim = 9'd1;
    else if (int'(gh_r) > MaxRows) h_dim = 9'(MaxRows);
    else                        h_dim = 9'(gh_r);
  end

  logic          goal_ok;
  logic [AW-1:0] goal_addr;
  assign goal_ok   = !gc_r[6] && !gr_r[6] && (9'(gc_r) < w_dim) && (9'(gr_r) < h_dim);
  assign goal_addr = {RW'(gr_r[5:0]), CW'(gc_r[5:0])};

  // latched request
  logic [1:0] op_r;
  logic [5:0] col_r, row_r;
  logic       wf_r;
  logic       in_store;

  always_ff @(posedge clk) begin
    if (cmd.in_latch) begin
      op_r  <= in_op;
      col_r <= in_col;
      row_r <= in_row;
      wf_r  <= in_wall;
    end
  end

  assign in_store = (int'(col_r) < MaxCols) && (int'(row_r) < MaxRows);

  // search registers
  logic          computed_r;
  logic [DW-1:0] max_r;
  logic [AW-1:0] clr_cnt_r;
  logic [AW:0]   head_r, tail_r;
  logic [RW-1:0] u_row_r;
  logic [CW-1:0] u_col_r;
  logic [DW-1:0] du_r;
  logic [1:0]    nb_r;

  // memories
  logic          wall_mem [Depth];
  logic [DW-1:0] dist_mem [Depth];
  logic [AW-1:0] q_mem    [Depth];
  logic          wall_rd_r;
  logic [DW-1:0] dist_rd_r;
  logic [AW-1:0] q_rd_r;

  // neighbor of the current cell
  logic          nb_legal;
  logic [RW-1:0] nb_row;
  logic [CW-1:0] nb_col;
  always_comb begin
    nb_row = u_row_r;
    nb_col = u_col_r;
    case (nb_r)
      2'd0: begin
        nb_legal = (u_col_r != '0);
        nb_col   = u_col_r - CW'(1);
      end
      2'd1: begin
        nb_legal = (9'(u_col_r) + 9'd1) < w_dim;
        nb_col   = u_col_r + CW'(1);
      end
      2'd2: begin
        nb_legal = (u_row_r != '0);
        nb_row   = u_row_r - RW'(1);
      end
      default: begin
        nb_legal = (9'(u_row_r) + 9'd1) < h_dim;
        nb_row   = u_row_r + RW'(1);
      end
    endcase
  end

  logic [AW-1:0] nb_addr;
  logic [DW-1:0] nd;
  logic          fresh;
  assign nb_addr = {nb_row, nb_col};
  assign nd      = (du_r == gsd_pkg::DIST_SAT) ? gsd_pkg::DIST_SAT : du_r + DW'(1);
  assign fresh   = cmd.nb_visit && (dist_rd_r == gsd_pkg::DIST_NONE) && !wall_rd_r;

  // read address
  logic [AW-1:0] rd_addr;
  always_comb begin
    case (cmd.rd_sel)
      gsd_pkg::RD_U:  rd_addr = q_rd_r;
      gsd_pkg::RD_NB: rd_addr = nb_addr;
      default:        rd_addr = {RW'(row_r), CW'(col_r)};
    endcase
  end

  // distance write port
  logic          d_we;
  logic [AW-1:0] d_waddr;
  logic [DW-1:0] d_wdata;
  always_comb begin
    d_we    = 1'b0;
    d_waddr = clr_cnt_r;
    d_wdata = gsd_pkg::DIST_NONE;
    if (cmd.clr_step) begin
      d_we = 1'b1;
    end else if (cmd.goal_init && goal_ok) begin
      d_we    = 1'b1;
      d_waddr = goal_addr;
      d_wdata = '0;
    end else if (fresh) begin
      d_we    = 1'b1;
      d_waddr = nb_addr;
      d_wdata = nd;
    end
  end

  logic          q_we;
  logic [AW-1:0] q_wdata;
  assign q_we    = (cmd.goal_init && goal_ok) || fresh;
  assign q_wdata = fresh ? nb_addr : goal_addr;

  always_ff @(posedge clk) begin
    if (cmd.wall_wr && in_store) wall_mem[{RW'(row_r), CW'(col_r)}] <= wf_r;
    if (d_we) dist_mem[d_waddr] <= d_wdata;
    if (q_we) q_mem[tail_r[AW-1:0]] <= q_wdata;
    wall_rd_r <= wall_mem[rd_addr];
    dist_rd_r <= dist_mem[rd_addr];
    q_rd_r    <= q_mem[head_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      computed_r <= 1'b0;
      max_r      <= gsd_pkg::DIST_NONE;
    end else begin
      if (cmd.clr_start) begin
        computed_r <= 1'b1;
        max_r      <= gsd_pkg::DIST_NONE;
      end else if (cmd.goal_init && goal_ok) begin
        max_r <= '0;
      end else if (fresh) begin
        max_r <= nd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_start) begin
      clr_cnt_r <= '0;
      head_r    <= '0;
      tail_r    <= '0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.pop) head_r <= head_r + (AW+1)'(1);
      if (q_we) tail_r <= tail_r + (AW+1)'(1);
    end
    if (cmd.u_latch) begin
      u_row_r <= q_rd_r[AW-1:CW];
      u_col_r <= q_rd_r[CW-1:0];
    end
    if (cmd.du_latch) begin
      du_r <= dist_rd_r;
      nb_r <= 2'd0;
    end else if (cmd.nb_next) begin
      nb_r <= nb_r + 2'd1;
    end
    if (cmd.out_load) begin
      if (op_r == gsd_pkg::OP_READ) begin
        out_dist_r <= (computed_r && in_store) ? dist_rd_r : gsd_pkg::DIST_NONE;
      end else begin
        out_dist_r <= '0;
      end
      out_max_r <= max_r;
    end
  end

  always_comb begin
    stat.op       = op_r;
    stat.clr_last = (clr_cnt_r == AW'(Depth - 1));
    stat.q_empty  = (head_r == tail_r);
    stat.u_wall   = wall_rd_r;
    stat.nb_legal = nb_legal;
    stat.nb_last  = (nb_r == 2'd3);
  end

endmodule

[rtl/core/grid_shortest_distance_map.sv]
// Top level: 4-connected grid distance map with controller and datapath.
// Compute: a clearing sweep over all 2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) distance entries,
//   then a breadth-first search from the goal that expands each reached open cell's neighbors.
// One request at a time; the next is taken the cycle after the result is taken.
// Reset (synchronous, rst_n low): config to 64x64 with no goal, every cell -1.
module grid_shortest_distance_map #(
  parameter int MaxCols = gsd_pkg::DEF_MAX_COLS,
  parameter int MaxRows = gsd_pkg::DEF_MAX_ROWS
) (
  input logic      clk,
  input logic      rst_n,
  gsd_in_if.sink   in_req,
  gsd_out_if.source out_rsp,
  gsd_cfg_if.sink  cfg_wr
);

  gsd_pkg::gsd_cmd_t  cmd;
  gsd_pkg::gsd_stat_t stat;
  logic [gsd_pkg::DIST_W-1:0] dist_q, max_q;

  // config writes are registered, always ready
  assign cfg_wr.ready = 1'b1;

  gsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gsd_dp #(
    .MaxCols (MaxCols),
    .MaxRows (MaxRows)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (in_req.op),
    .in_col     (in_req.cell_col),
    .in_row     (in_req.cell_row),
    .in_wall    (in_req.wall_flag),
    .cfg_we     (cfg_wr.valid),
    .cfg_index  (cfg_wr.index),
    .cfg_data   (cfg_wr.data),
    .cmd        (cmd),
    .stat       (stat),
    .out_dist_r (dist_q),
    .out_max_r  (max_q)
  );

  // result register drives the payload directly
  assign out_rsp.cell_distance = $signed(dist_q);
  assign out_rsp.peak_distance = $signed(max_q);

endmodule

[tb/tb_grid_shortest_distance_map.sv]
// Testbench for the grid shortest distance map: directed and random requests checked against a BFS predictor.
module tb_grid_shortest_distance_map;

  timeunit 1ns;
  timeprecision 1ps;

  // Op code with no defined function: the block answers with 0 and the current max.
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int NCELLS = gsd_pkg::DEF_MAX_COLS * gsd_pkg::DEF_MAX_ROWS;

  typedef struct packed {
    logic signed [12:0] cell_distance;
    logic signed [12:0] peak_distance;
  } dist_result_t;

  logic clk;
  logic rst_n;

  gsd_in_if  in_if ();
  gsd_out_if out_if ();
  gsd_cfg_if cfg_if ();

  grid_shortest_distance_map DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_if),
    .out_rsp (out_if),
    .cfg_wr  (cfg_if)
  );

  // Predictor copy of the block: registers, wall map, distance map and max.
  logic [6:0]  pr_width, pr_height, pr_goal_col, pr_goal_row;
  bit          pr_wall [NCELLS];
  logic [12:0] pr_dist [NCELLS];
  logic [12:0] pr_max;

  dist_result_t expected_dists[$];
  int errors;
  int in_idle_pct, out_idle_pct;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [12:0] sat13(int d);
    return (d > 4095) ? 13'd4095 : d[12:0];
  endfunction

  function automatic int clamp_dim(logic [6:0] v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // Breadth-first flood from the goal over 4-connected open cells.
  function automatic void flood_distances();
    int w, h, gc, gr, best, u, c, r, nd, nb;
    int fifo[$];
    int dval[NCELLS];
    bit seen[NCELLS];
    w = clamp_dim(pr_width, gsd_pkg::DEF_MAX_COLS);
    h = clamp_dim(pr_height, gsd_pkg::DEF_MAX_ROWS);
    gc = int'(pr_goal_col);
    gr = int'(pr_goal_row);
    best = 0;
    foreach (pr_dist[i]) pr_dist[i] = gsd_pkg::DIST_NONE;
    pr_max = gsd_pkg::DIST_NONE;
    // A negative goal has bit 6 set and so also lands outside the grid.
    if (pr_goal_col[6] || pr_goal_row[6] || gc >= w || gr >= h) return;
    u = gr * gsd_pkg::DEF_MAX_COLS + gc;
    seen[u] = 1'b1;
    dval[u] = 0;
    fifo = {fifo, u};
    while (fifo.size() > 0) begin
      u = fifo.pop_front();
      c = u % gsd_pkg::DEF_MAX_COLS;
      r = u / gsd_pkg::DEF_MAX_COLS;
      nd = dval[u] + 1;
      pr_dist[u] = sat13(dval[u]);
      if (dval[u] > best) best = dval[u];
      // A goal on a wall keeps distance 0 but is never expanded.
      if (pr_wall[u]) continue;
      for (int k = 0; k < 4; k++) begin
        nb = -1;
        case (k)
          0: if (c > 0) nb = u - 1;
          1: if (c + 1 < w) nb = u + 1;
          2: if (r > 0) nb = u - gsd_pkg::DEF_MAX_COLS;
          default: if (r + 1 < h) nb = u + gsd_pkg::DEF_MAX_COLS;
        endcase
        if (nb >= 0 && !seen[nb] && !pr_wall[nb]) begin
          seen[nb] = 1'b1;
          dval[nb] = nd;
          fifo = {fifo, nb};
        end
      end
    end
    pr_max = sat13(best);
  endfunction

  function automatic dist_result_t predict_request(logic [1:0] op, logic [5:0] col,
                                                   logic [5:0] row, logic wf);
    dist_result_t res;
    int idx;
    idx = int'(row) * gsd_pkg::DEF_MAX_COLS + int'(col);
    res.cell_distance = '0;
    case (op)
      gsd_pkg::OP_WALL: pr_wall[idx] = wf;
      gsd_pkg::OP_COMPUTE: flood_distances();
      gsd_pkg::OP_READ: res.cell_distance = pr_dist[idx];
      default: ;
    endcase
    res.peak_distance = pr_max;
    return res;
  endfunction

  // Receiver: random backpressure, then check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    dist_result_t exp_res;
    out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_dists.size() == 0) begin
        $error("result with nothing expected: cell_distance %0d peak_distance %0d",
               out_if.cell_distance, out_if.peak_distance);
        errors++;
      end else begin
        exp_res = expected_dists.pop_front();
        if (out_if.cell_distance !== exp_res.cell_distance) begin
          $error("cell_distance expected %0d got %0d", exp_res.cell_distance,
                 out_if.cell_distance);
          errors++;
        end
        if (out_if.peak_distance !== exp_res.peak_distance) begin
          $error("peak_distance expected %0d got %0d", exp_res.peak_distance,
                 out_if.peak_distance);
          errors++;
        end
      end
    end
  end

  // Send one request; valid stays high after acceptance so back-to-back requests need no gap.
  task automatic send_request(logic [1:0] op, logic [5:0] col, logic [5:0] row, logic wf);
    int gap;
    gap = ($urandom_range(99) < in_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.cell_col  <= col;
    in_if.cell_row  <= row;
    in_if.wall_flag <= wf;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    expected_dists = {expected_dists, predict_request(op, col, row, wf)};
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_dists.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; call only while the block is idle.
  task automatic write_reg(logic [1:0] index, logic [6:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    case (index)
      gsd_pkg::REG_GRID_WIDTH:  pr_width = data;
      gsd_pkg::REG_GRID_HEIGHT: pr_height = data;
      gsd_pkg::REG_GOAL_COL:    pr_goal_col = data;
      default:                  pr_goal_row = data;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(logic [6:0] w, logic [6:0] h, logic [6:0] gc, logic [6:0] gr);
    drain();
    write_reg(gsd_pkg::REG_GRID_WIDTH, w);
    write_reg(gsd_pkg::REG_GRID_HEIGHT, h);
    write_reg(gsd_pkg::REG_GOAL_COL, gc);
    write_reg(gsd_pkg::REG_GOAL_ROW, gr);
  endtask

  task automatic write_drained_goal(logic [6:0] gc, logic [6:0] gr);
    drain();
    write_reg(gsd_pkg::REG_GOAL_COL, gc);
    write_reg(gsd_pkg::REG_GOAL_ROW, gr);
    send_request(gsd_pkg::OP_COMPUTE, 6'd0, 6'd0, 1'b0);
  endtask

  // Reset state, small hand-built maps and goal corner cases.
  task automatic test_directed();
    in_idle_pct = 19;
    out_idle_pct = 48;
    // Fresh after reset: every cell unreachable, no max; no goal, so compute reads no walls.
    send_request(gsd_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
    send_request(OP_NOP, 6'd63, 6'd63, 1'b1);
    send_request(gsd_pkg::OP_COMPUTE, 6'd0, 6'd0, 1'b0);
    send_request(gsd_pkg::OP_READ, 6'd63, 6'd63, 1'b0);
    // 3x2 grid, wall at (1,0), goal in the far corner.
    set_grid(7'd3, 7'd2, 7'd2, 7'd1);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 3; c++)
        send_request(gsd_pkg::OP_WALL, c[5:0], r[5:0], (c == 1 && r == 0));
    send_request(gsd_pkg::OP_COMPUTE, 6'd0, 6'd0, 1'b0);
    send_request(gsd_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
    send_request(gsd_pkg::OP_READ, 6'd1, 6'd0, 1'b0);
    send_request(gsd_pkg::OP_READ, 6'd63, 6'd63, 1'b0);
    // Goal on a wall: goal reads 0, everything else unreachable.
    send_request(gsd_pkg::OP_WALL, 6'd2, 6'd1, 1'b1);
    send_request(gsd_pkg::OP_COMPUTE, 6'd0, 6'd0, 1'b0);
    send_request(gsd_pkg::OP_READ, 6'd2, 6'd1, 1'b0);
    send_request(gsd_pkg::OP_READ, 6'd2, 6'd0, 1'b0);
    // Goal one past the grid edge.
    set_grid(7'd3, 7'd2, 7'd3, 7'd0);
    send_request(gsd_pkg::OP_COMPUTE, 6'd0, 6'd0, 1'b0);
    send_request(gsd_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
    // Width 0 counts as 1; negative goal row.
    set_grid(7'd0, 7'd2, 7'h7F, 7'h40);
    send_request(gsd_pkg::OP_COMPUTE, 6'd0, 6'd0, 1'b0);
    write_drained_goal(7'd0, 7'd1);
    send_request(gsd_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
    drain();
  endtask

  // Random maps: fill every cell in use, compute, then a random mix of requests.
  task automatic run_random_phase(int in_pct, int out_pct, int n_items, int first_shape);
    int count, w, h, gc, gr, n_mix, pick;
    logic [5:0] col, row;
    count = 0;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    while (count < n_items) begin
      if (first_shape == 1) begin
        // Width above the maximum counts as 64.
        w = 64; h = 1; gc = 63; gr = 0;
        set_grid(7'd100, 7'd1, 7'd63, 7'd0);
      end else begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 6);
        gc = $urandom_range(0, w);
        gr = $urandom_range(0, h - 1);
        if ($urandom_range(9) == 0) gr = -1;
        set_grid(w[6:0], h[6:0], gc[6:0], gr[6:0]);
      end
      first_shape = 0;
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++)
          send_request(gsd_pkg::OP_WALL, c[5:0], r[5:0], ($urandom_range(99) < 25));
      send_request(gsd_pkg::OP_COMPUTE, 6'd0, 6'd0, 1'b0);
      count += w * h + 1;
      n_mix = $urandom_range(6, 14);
      for (int k = 0; k < n_mix; k++) begin
        pick = $urandom_range(99);
        if ($urandom_range(9) < 7) begin
          col = 6'($urandom_range(0, w - 1));
          row = 6'($urandom_range(0, h - 1));
        end else begin
          col = 6'($urandom);
          row = 6'($urandom);
        end
        if (pick < 55)      send_request(gsd_pkg::OP_READ, col, row, 1'($urandom));
        else if (pick < 80) send_request(gsd_pkg::OP_WALL, col, row, 1'($urandom));
        else if (pick < 90) send_request(gsd_pkg::OP_COMPUTE, col, row, 1'($urandom));
        else                send_request(OP_NOP, col, row, 1'($urandom));
        count++;
      end
      // Hold off new requests until the block has answered everything.
      drain();
    end
  endtask

  initial begin
    errors = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = gsd_pkg::OP_WALL;
    in_if.cell_col = '0;
    in_if.cell_row = '0;
    in_if.wall_flag = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = gsd_pkg::REG_GRID_WIDTH;
    cfg_if.data = '0;
    pr_width = 7'd64;
    pr_height = 7'd64;
    pr_goal_col = 7'h7F;
    pr_goal_row = 7'h7F;
    pr_max = gsd_pkg::DIST_NONE;
    foreach (pr_dist[i]) pr_dist[i] = gsd_pkg::DIST_NONE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    run_random_phase(19, 48, 40, 1);
    run_random_phase(48, 19, 20, 0);
    run_random_phase(0, 0, 20, 0);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_dists.size() == 0) begin
      $display("tb_grid_shortest_distance_map: done, clean");
    end else begin
      $display("tb_grid_shortest_distance_map: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40ms;
    $display("tb_grid_shortest_distance_map: done, errors");
    $finish;
  end

endmodule
